// ===== rtl/core/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and fixed field widths for the move-to-front depth block.
// ----------------------------------------------------------------------------
package mtf_pkg;

   // Fixed widths of the transaction fields and the count register.
   localparam int ITEM_W  = 9;
   localparam int COUNT_W = 9;
   localparam int DEPTH_W = 8;

   // Item count after reset.
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   // Input kind codes.
   localparam logic KIND_ACCESS  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // Engine sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_FINISH
   } mtf_state_type;

   // Command handed from the front end to the engine.
   typedef struct packed {
      logic restart;
      logic bad;
   } mtf_cmd_type;

   // Result handed from the engine to the output stage.
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               bad;
   } mtf_res_type;

endpackage

// ===== rtl/core/move_to_front_depth.sv =====
// ----------------------------------------------------------------------------
// move_to_front_depth
// Move-to-front transform: returns the depth of an accessed item in a stack
// and moves that item to the top.
// ----------------------------------------------------------------------------
// Each item's rank lives in one single-port-read, single-port-write memory of
// MAX_ITEMS entries. A valid access makes one lookup read of the item's rank,
// then one sweep through every entry of the rank memory that reads, adjusts
// and writes back each rank, then hands its result to the output register,
// waiting while that register is full and its result not taken. The next
// transaction is accepted only after the result has been handed on, so
// accesses do not overlap. A restart rewrites the whole table and gives no
// result; the next transaction is accepted once that clearing pass is done.
// After reset the same clearing pass runs before the first transaction is
// accepted. An access with an item of 0, above the item count or above
// MAX_ITEMS is answered without lookup or sweep, with bad_item set, and
// leaves the stack unchanged. Depth is the rank masked to 8 bits. The result
// sits in an output register, so the next transaction is accepted while a
// result still waits to be taken.
// ----------------------------------------------------------------------------
module move_to_front_depth #(
   parameter int MAX_ITEMS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] item, [15:9] zero
   input  logic        req_tuser,   // [0] kind
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] depth
   output logic        rsp_tuser,   // [0] bad_item
   // Configuration
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata    // item_count
);
   import mtf_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);

   logic [COUNT_W-1:0] item_count_ff;
   logic [ITEM_W-1:0]  item;
   logic               item_bad;
   mtf_cmd_type        cmd;
   logic [AW-1:0]      cmd_slot;
   logic               cmd_ready;
   logic               res_valid;
   logic               res_ready;
   mtf_res_type        res;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_bad_ff;

   // Item count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         item_count_ff <= csr_wdata;
      end
   end

   // Decode the incoming transaction and check the item number.
   assign item     = req_tdata[ITEM_W-1:0];
   assign item_bad = (item == '0) || (item > item_count_ff) || (32'(item) > MAX_ITEMS);
   assign cmd.restart = (req_tuser == KIND_RESTART);
   assign cmd.bad     = item_bad;
   assign cmd_slot    = AW'(item - ITEM_W'(1));

   mtf_engine #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .cmd_slot  (cmd_slot),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign req_tready = cmd_ready;

   // Output register: loads when empty or when its transaction is taken.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res.depth;
         rsp_bad_ff  <= res.bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

// ===== rtl/core/mtf_ram.sv =====
// ----------------------------------------------------------------------------
// mtf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/mtf_engine.sv =====
// ----------------------------------------------------------------------------
// mtf_engine
// Rank table sequencer: initializes the table, looks up one rank and sweeps
// every entry through the rank memory to move the accessed item to the top.
// ----------------------------------------------------------------------------
module mtf_engine #(
   parameter int MAX_ITEMS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  mtf_pkg::mtf_cmd_type         cmd,
   input  logic [$clog2(MAX_ITEMS)-1:0] cmd_slot,
   output logic                         res_valid,
   input  logic                         res_ready,
   output mtf_pkg::mtf_res_type         res
);
   import mtf_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam logic [AW-1:0] LAST = AW'(MAX_ITEMS - 1);

   mtf_state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] slot_ff;
   logic [AW-1:0] rank_ff;
   logic          bad_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] rd_data;
   logic [AW-1:0] cnt_next;

   // Rank memory, one entry per item.
   mtf_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_ITEMS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_next = (cnt_ff == LAST) ? '0 : cnt_ff + AW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (cnt_ff == LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.restart)  state_in = ST_INIT;
               else if (cmd.bad) state_in = ST_FINISH;
               else              state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (cnt_ff == LAST) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Memory control and handshake outputs.
   always_comb begin
      cmd_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = cnt_ff;
      wr_data   = cnt_ff;
      rd_addr   = '0;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_INIT: begin
            // Clearing pass: entry k gets rank k.
            wr_en  = 1'b1;
            cnt_in = cnt_next;
         end
         ST_IDLE: begin
            cmd_ready = 1'b1;
            rd_addr   = cmd_slot;
            cnt_in    = '0;
         end
         ST_LOOKUP: begin
            rd_addr = '0;
         end
         ST_SWEEP: begin
            // Entry cnt_ff arrives now; the next one is requested.
            rd_addr = cnt_next;
            wr_en   = 1'b1;
            if (cnt_ff == slot_ff) begin
               wr_data = '0;
            end else if (rd_data < rank_ff) begin
               wr_data = rd_data + AW'(1);
            end else begin
               wr_data = rd_data;
            end
            cnt_in = cnt_next;
         end
         ST_FINISH: begin
            res_valid = 1'b1;
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   assign res.depth = bad_ff ? '0 : DEPTH_W'(rank_ff);
   assign res.bad   = bad_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Per-transaction working registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_valid) begin
         slot_ff <= cmd_slot;
         bad_ff  <= cmd.bad;
      end
      if (state_ff == ST_LOOKUP) begin
         rank_ff <= rd_data;
      end
   end

endmodule
